>>> design/ctdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdr_pkg
// Shared types, widths and helpers for the colour-to-depth reprojection.
// ----------------------------------------------------------------------------
package ctdr_pkg;

   localparam int COORD_FRAC_BITS = 4;
   localparam int PIX_SHIFT       = 16 - COORD_FRAC_BITS;

   localparam int QBITS  = 40;          // quotient bits kept by a divider
   localparam int DVD_W  = 94;          // dividend width
   localparam int DVS_W  = 62;          // divisor width
   localparam int Q_W    = QBITS + 1;   // signed quotient width
   localparam int SIDE_W = 49;          // sideband through the long stages
   localparam int P_W    = 43;          // translated point, Q.16 mm
   localparam int PD_W   = 64;          // rotated point, Q.34 mm
   localparam int OUT_W  = 21;
   localparam int S_W    = Q_W + 2;     // quotient plus centre
   localparam int R_W    = S_W - PIX_SHIFT;

   localparam logic [QBITS-1:0] INNER_CAP = '1;

   typedef enum logic [3:0] {
      REG_COLOR_FOCAL  = 4'd0,
      REG_COLOR_CENTER = 4'd1,
      REG_DEPTH_FOCAL  = 4'd2,
      REG_DEPTH_CENTER = 4'd3,
      REG_ROT_ROW0     = 4'd4,
      REG_ROT_ROW1     = 4'd5,
      REG_ROT_ROW2     = 4'd6,
      REG_TRANSLATION  = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [63:0]      color_focal;
      logic [63:0]      color_center;
      logic [63:0]      depth_focal;
      logic [63:0]      depth_center;
      logic [2:0][62:0] rot_row;
      logic [62:0]      translation;
   } cfg_type;

   typedef struct packed {
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      logic signed [Q_W-1:0] quot;
      logic                  sat;
   } div_res_type;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             sat;
   } fin_type;

   function automatic logic signed [20:0] field21(input logic [62:0] word,
                                                  input int k);
      field21 = $signed(word[21*k +: 21]);
   endfunction

   // (q + center) / 2^PIX_SHIFT, toward zero, clamped to 21 bits
   function automatic fin_type finish(input logic signed [Q_W-1:0] q,
                                      input logic [31:0] center);
      logic signed [S_W-1:0] s;
      logic signed [R_W-1:0] r;
      fin_type               f;
      s = S_W'(q) + $signed({{(S_W-32){1'b0}}, center});
      if (s[S_W-1]) begin
         s = s + S_W'((1 << PIX_SHIFT) - 1);
      end
      r = R_W'(s >>> PIX_SHIFT);
      f.sat = 1'b0;
      if (r > R_W'((1 << (OUT_W-1)) - 1)) begin
         f.value = {1'b0, {(OUT_W-1){1'b1}}};
         f.sat   = 1'b1;
      end else if (r < -R_W'(1 << (OUT_W-1))) begin
         f.value = {1'b1, {(OUT_W-1){1'b0}}};
         f.sat   = 1'b1;
      end else begin
         f.value = r[OUT_W-1:0];
      end
      return f;
   endfunction

endpackage

>>> design/ctdr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdr_req_if
// Input word channel: colour pixel and its depth.
// ----------------------------------------------------------------------------
interface ctdr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] color_u;
   logic [15:0] color_v;
   logic [15:0] depth_mm;
   modport source (output valid, color_u, color_v, depth_mm, input ready);
   modport sink   (input valid, color_u, color_v, depth_mm, output ready);
endinterface

>>> design/ctdr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdr_rsp_if
// Result word channel: depth image coordinate and flags.
// ----------------------------------------------------------------------------
interface ctdr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] depth_u;
   logic signed [20:0] depth_v;
   logic               degenerate;
   logic               saturated;
   modport source (output valid, depth_u, depth_v, degenerate, saturated, input ready);
   modport sink   (input valid, depth_u, depth_v, degenerate, saturated, output ready);
endinterface

>>> design/ctdr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdr_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ctdr_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  ctdr_pkg::div_lane_type [1:0]         lane_in,
   input  logic [ctdr_pkg::SIDE_W-1:0]          side_in,
   output logic                                 out_valid,
   output ctdr_pkg::div_res_type [1:0]          res_out,
   output logic [ctdr_pkg::SIDE_W-1:0]          side_out
);
   localparam int NS = ctdr_pkg::QBITS + 1;

   logic [NS-1:0]                          v_ff;
   logic [ctdr_pkg::SIDE_W-1:0]            side_ff [NS];
   logic [1:0][ctdr_pkg::DVS_W-1:0]        rem_ff  [NS];
   logic [1:0][ctdr_pkg::QBITS-1:0]        lo_ff   [NS];
   logic [1:0][ctdr_pkg::DVS_W-1:0]        dvs_ff  [NS];
   logic [1:0]                             neg_ff  [NS];
   logic [1:0]                             zero_ff [NS];
   logic [1:0]                             big_ff  [NS];

   // stage 0: zero and overflow checks, high dividend bits as first remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l]  <= ctdr_pkg::DVS_W'(lane_in[l].dividend[ctdr_pkg::DVD_W-1:
                                                                  ctdr_pkg::QBITS]);
            lo_ff[0][l]   <= lane_in[l].dividend[ctdr_pkg::QBITS-1:0];
            dvs_ff[0][l]  <= lane_in[l].divisor;
            neg_ff[0][l]  <= lane_in[l].neg;
            zero_ff[0][l] <= (lane_in[l].dividend == '0);
            big_ff[0][l]  <= ({{(ctdr_pkg::DVS_W+ctdr_pkg::QBITS-ctdr_pkg::DVD_W){1'b0}},
                               lane_in[l].dividend} >=
                              {lane_in[l].divisor, {ctdr_pkg::QBITS{1'b0}}});
         end
      end
   end

   for (genvar k = 1; k < NS; k++) begin : g_step
      logic [1:0][ctdr_pkg::DVS_W-1:0] rem_in;
      logic [1:0][ctdr_pkg::QBITS-1:0] lo_in;

      always_comb begin
         logic [ctdr_pkg::DVS_W:0] t;
         for (int l = 0; l < 2; l++) begin
            t = {rem_ff[k-1][l], lo_ff[k-1][l][ctdr_pkg::QBITS-1]};
            if (t >= {1'b0, dvs_ff[k-1][l]}) begin
               t         = t - {1'b0, dvs_ff[k-1][l]};
               lo_in[l]  = {lo_ff[k-1][l][ctdr_pkg::QBITS-2:0], 1'b1};
            end else begin
               lo_in[l]  = {lo_ff[k-1][l][ctdr_pkg::QBITS-2:0], 1'b0};
            end
            rem_in[l] = t[ctdr_pkg::DVS_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_ff[k-1];
            rem_ff[k]  <= rem_in;
            lo_ff[k]   <= lo_in;
            dvs_ff[k]  <= dvs_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            big_ff[k]  <= big_ff[k-1];
         end
      end
   end

   // lo now holds the quotient; apply the clamp and the sign
   always_comb begin
      logic [ctdr_pkg::QBITS-1:0] q;
      for (int l = 0; l < 2; l++) begin
         if (zero_ff[NS-1][l]) begin
            q = '0;
         end else if (big_ff[NS-1][l]) begin
            q = ctdr_pkg::INNER_CAP;
         end else begin
            q = lo_ff[NS-1][l];
         end
         res_out[l].sat  = !zero_ff[NS-1][l] && big_ff[NS-1][l];
         res_out[l].quot = neg_ff[NS-1][l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
   end

   assign out_valid = v_ff[NS-1];
   assign side_out  = side_ff[NS-1];

endmodule

>>> design/ctdr_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdr_rot
// Translation and transposed rotation of the back-projected point, 3 stages.
// ----------------------------------------------------------------------------
module ctdr_rot (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  logic                                         in_valid,
   input  logic signed [ctdr_pkg::Q_W-1:0]              xc,
   input  logic signed [ctdr_pkg::Q_W-1:0]              yc,
   input  logic [15:0]                                  z,
   input  ctdr_pkg::cfg_type                            cfg,
   input  logic [ctdr_pkg::SIDE_W-1:0]                  side_in,
   output logic                                         out_valid,
   output logic signed [2:0][ctdr_pkg::PD_W-1:0]        pd,
   output logic [ctdr_pkg::SIDE_W-1:0]                  side_out
);
   logic [2:0]                               v_ff;
   logic [ctdr_pkg::SIDE_W-1:0]              side_ff [3];
   logic signed [2:0][ctdr_pkg::P_W-1:0]     p_ff;
   logic signed [8:0][ctdr_pkg::PD_W-1:0]    prod_ff;
   logic signed [2:0][ctdr_pkg::PD_W-1:0]    pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         // P = Pc - t, Q.16 mm
         p_ff[0] <= ctdr_pkg::P_W'(xc) -
                    (ctdr_pkg::P_W'(ctdr_pkg::field21(cfg.translation, 0)) <<< 16);
         p_ff[1] <= ctdr_pkg::P_W'(yc) -
                    (ctdr_pkg::P_W'(ctdr_pkg::field21(cfg.translation, 1)) <<< 16);
         p_ff[2] <= (ctdr_pkg::P_W'($signed({1'b0, z})) -
                     ctdr_pkg::P_W'(ctdr_pkg::field21(cfg.translation, 2))) <<< 16;
         // element selects are unsigned: sign-extend P explicitly
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[3*i+j] <= ctdr_pkg::PD_W'(ctdr_pkg::field21(cfg.rot_row[i], j)) *
                                 ctdr_pkg::PD_W'($signed(p_ff[i]));
            end
         end
         for (int j = 0; j < 3; j++) begin
            pd_ff[j] <= prod_ff[j] + prod_ff[3+j] + prod_ff[6+j];
         end
      end
   end

   assign out_valid = v_ff[2];
   assign pd        = pd_ff;
   assign side_out  = side_ff[2];

endmodule

>>> design/color_to_depth_pixel_reprojection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_to_depth_pixel_reprojection
// Colour pixel plus depth to depth-camera pixel through the pinhole models.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not held back; the two
// 41-stage divider pipelines set depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (synchronous, high) clears all valid bits and the configuration
// registers to 0; datapath registers are not reset.
// ----------------------------------------------------------------------------
module color_to_depth_pixel_reprojection (
   input  logic              clock,
   input  logic              reset,
   ctdr_req_if.sink          req_ch,
   ctdr_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [3:0]        csr_index,
   input  logic [63:0]       csr_data
);
   ctdr_pkg::cfg_type cfg_ff;
   logic adv;

   // output register drains or is empty: everything shifts one stage
   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (ctdr_pkg::reg_index_type'(csr_index))
            ctdr_pkg::REG_COLOR_FOCAL:  cfg_ff.color_focal  <= csr_data;
            ctdr_pkg::REG_COLOR_CENTER: cfg_ff.color_center <= csr_data;
            ctdr_pkg::REG_DEPTH_FOCAL:  cfg_ff.depth_focal  <= csr_data;
            ctdr_pkg::REG_DEPTH_CENTER: cfg_ff.depth_center <= csr_data;
            ctdr_pkg::REG_ROT_ROW0:     cfg_ff.rot_row[0]   <= csr_data[62:0];
            ctdr_pkg::REG_ROT_ROW1:     cfg_ff.rot_row[1]   <= csr_data[62:0];
            ctdr_pkg::REG_ROT_ROW2:     cfg_ff.rot_row[2]   <= csr_data[62:0];
            ctdr_pkg::REG_TRANSLATION:  cfg_ff.translation  <= csr_data[62:0];
            default: ;
         endcase
      end
   end

   // ---- stage 1: offsets from the colour centre, Q.16 pixels
   logic        s1_v_ff;
   logic [31:0] s1_mu_ff, s1_mv_ff, s1_b_ff;
   logic        s1_nu_ff, s1_nv_ff;
   logic [47:0] s1_side_ff;
   logic signed [33:0] du, dv;

   assign du = $signed({2'b00, 32'(req_ch.color_u) << ctdr_pkg::PIX_SHIFT}) -
               $signed({2'b00, cfg_ff.color_center[63:32]});
   assign dv = $signed({2'b00, 32'(req_ch.color_v) << ctdr_pkg::PIX_SHIFT}) -
               $signed({2'b00, cfg_ff.color_center[31:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_nu_ff   <= du[33];
         s1_nv_ff   <= dv[33];
         s1_mu_ff   <= du[33] ? 32'(-du) : du[31:0];
         s1_mv_ff   <= dv[33] ? 32'(-dv) : dv[31:0];
         s1_b_ff    <= {req_ch.depth_mm, 16'h0000};
         s1_side_ff <= {req_ch.color_u, req_ch.color_v, req_ch.depth_mm};
      end
   end

   // ---- stage 2: |d| * Z * 2^16
   logic        s2_v_ff;
   logic [63:0] s2_pu_ff, s2_pv_ff;
   logic        s2_nu_ff, s2_nv_ff;
   logic [47:0] s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pu_ff   <= 64'(s1_mu_ff) * 64'(s1_b_ff);
         s2_pv_ff   <= 64'(s1_mv_ff) * 64'(s1_b_ff);
         s2_nu_ff   <= s1_nu_ff;
         s2_nv_ff   <= s1_nv_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---- divide by the colour focal lengths
   ctdr_pkg::div_lane_type [1:0] d1_lane;
   ctdr_pkg::div_res_type  [1:0] d1_res;
   logic                          d1_v;
   logic [ctdr_pkg::SIDE_W-1:0]   d1_side;

   always_comb begin
      d1_lane[0].dividend = ctdr_pkg::DVD_W'(s2_pu_ff);
      d1_lane[0].divisor  = ctdr_pkg::DVS_W'(cfg_ff.color_focal[63:32]);
      d1_lane[0].neg      = s2_nu_ff;
      d1_lane[1].dividend = ctdr_pkg::DVD_W'(s2_pv_ff);
      d1_lane[1].divisor  = ctdr_pkg::DVS_W'(cfg_ff.color_focal[31:0]);
      d1_lane[1].neg      = s2_nv_ff;
   end

   ctdr_div u_div_color (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s2_v_ff),
      .lane_in   (d1_lane),
      .side_in   ({1'b0, s2_side_ff}),
      .out_valid (d1_v),
      .res_out   (d1_res),
      .side_out  (d1_side)
   );

   // ---- translate and rotate; side word is {sat, u, v, z}
   logic                                   rot_v;
   logic signed [2:0][ctdr_pkg::PD_W-1:0]  rot_pd;
   logic [ctdr_pkg::SIDE_W-1:0]            rot_side;

   ctdr_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d1_v),
      .xc        (d1_res[0].quot),
      .yc        (d1_res[1].quot),
      .z         (d1_side[15:0]),
      .cfg       (cfg_ff),
      .side_in   ({d1_res[0].sat | d1_res[1].sat, d1_side[47:0]}),
      .out_valid (rot_v),
      .pd        (rot_pd),
      .side_out  (rot_side)
   );

   // ---- stage 6: z check, partial products of |Pd| and depth focal
   logic        s6_v_ff;
   logic [62:0] s6_ul_ff, s6_uh_ff, s6_vl_ff, s6_vh_ff;
   logic        s6_nu_ff, s6_nv_ff;
   logic [ctdr_pkg::DVS_W-1:0] s6_dvs_ff;
   logic [ctdr_pkg::SIDE_W-1:0] s6_side_ff;
   logic [61:0] m0, m1;

   assign m0 = rot_pd[0][63] ? 62'(-rot_pd[0]) : rot_pd[0][61:0];
   assign m1 = rot_pd[1][63] ? 62'(-rot_pd[1]) : rot_pd[1][61:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= rot_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ul_ff  <= 63'(m0[30:0])  * 63'(cfg_ff.depth_focal[63:32]);
         s6_uh_ff  <= 63'(m0[61:31]) * 63'(cfg_ff.depth_focal[63:32]);
         s6_vl_ff  <= 63'(m1[30:0])  * 63'(cfg_ff.depth_focal[31:0]);
         s6_vh_ff  <= 63'(m1[61:31]) * 63'(cfg_ff.depth_focal[31:0]);
         s6_nu_ff  <= rot_pd[0][63];
         s6_nv_ff  <= rot_pd[1][63];
         s6_dvs_ff <= rot_pd[2][ctdr_pkg::DVS_W-1:0];
         // {sat, degenerate, u, v}; z no longer needed
         s6_side_ff <= {rot_side[48], ($signed(rot_pd[2]) <= 0), rot_side[47:16],
                        {(ctdr_pkg::SIDE_W-34){1'b0}}};
      end
   end

   // ---- stage 7: assemble the full products
   logic        s7_v_ff;
   logic [ctdr_pkg::DVD_W-1:0] s7_pu_ff, s7_pv_ff;
   logic        s7_nu_ff, s7_nv_ff;
   logic [ctdr_pkg::DVS_W-1:0] s7_dvs_ff;
   logic [ctdr_pkg::SIDE_W-1:0] s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_pu_ff   <= ctdr_pkg::DVD_W'(s6_ul_ff) + (ctdr_pkg::DVD_W'(s6_uh_ff) << 31);
         s7_pv_ff   <= ctdr_pkg::DVD_W'(s6_vl_ff) + (ctdr_pkg::DVD_W'(s6_vh_ff) << 31);
         s7_nu_ff   <= s6_nu_ff;
         s7_nv_ff   <= s6_nv_ff;
         s7_dvs_ff  <= s6_dvs_ff;
         s7_side_ff <= s6_side_ff;
      end
   end

   // ---- divide by Pd_z (ignored when degenerate)
   ctdr_pkg::div_lane_type [1:0] d2_lane;
   ctdr_pkg::div_res_type  [1:0] d2_res;
   logic                          d2_v;
   logic [ctdr_pkg::SIDE_W-1:0]   d2_side;

   always_comb begin
      d2_lane[0].dividend = s7_pu_ff;
      d2_lane[0].divisor  = s7_dvs_ff;
      d2_lane[0].neg      = s7_nu_ff;
      d2_lane[1].dividend = s7_pv_ff;
      d2_lane[1].divisor  = s7_dvs_ff;
      d2_lane[1].neg      = s7_nv_ff;
   end

   ctdr_div u_div_depth (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s7_v_ff),
      .lane_in   (d2_lane),
      .side_in   (s7_side_ff),
      .out_valid (d2_v),
      .res_out   (d2_res),
      .side_out  (d2_side)
   );

   // ---- add depth centre, scale to output format, clamp; output register
   ctdr_pkg::fin_type fu, fv;
   logic              deg;
   logic [15:0]       pass_u, pass_v;

   assign fu     = ctdr_pkg::finish(d2_res[0].quot, cfg_ff.depth_center[63:32]);
   assign fv     = ctdr_pkg::finish(d2_res[1].quot, cfg_ff.depth_center[31:0]);
   assign deg    = d2_side[47];
   assign pass_u = d2_side[46:31];
   assign pass_v = d2_side[30:15];

   logic               out_v_ff;
   logic signed [20:0] out_u_ff, out_vv_ff;
   logic               out_deg_ff, out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (deg) begin
            out_u_ff   <= $signed({5'b00000, pass_u});
            out_vv_ff  <= $signed({5'b00000, pass_v});
            out_deg_ff <= 1'b1;
            out_sat_ff <= 1'b0;
         end else begin
            out_u_ff   <= $signed(fu.value);
            out_vv_ff  <= $signed(fv.value);
            out_deg_ff <= 1'b0;
            out_sat_ff <= d2_side[48] | d2_res[0].sat | d2_res[1].sat | fu.sat | fv.sat;
         end
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.depth_u    = out_u_ff;
   assign rsp_ch.depth_v    = out_vv_ff;
   assign rsp_ch.degenerate = out_deg_ff;
   assign rsp_ch.saturated  = out_sat_ff;

endmodule

>>> dv/color_to_depth_pixel_reprojection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_to_depth_pixel_reprojection_tb
// Self-checking bench for the colour-to-depth pixel reprojection. A driver
// feeds pixel words from a queue, a monitor takes result words under random
// back-pressure, and a fixed-point projection model predicts every result.
// Several camera setups are loaded between phases, extremes included.
// ----------------------------------------------------------------------------
module color_to_depth_pixel_reprojection_tb;

   localparam int  LATENCY     = 90;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam longint PIX_CAP  = 64'hFF_FFFF_FFFF;   // inner clamp, 2^40-1
   localparam longint PIX_MAX  = 1048575;
   localparam longint PIX_MIN  = -1048576;

   typedef struct packed {
      logic [15:0] u;
      logic [15:0] v;
      logic [15:0] z;
   } pixel_type;

   typedef struct packed {
      logic [20:0] du;
      logic [20:0] dv;
      logic        degen;
      logic        sat;
   } proj_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we    = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data  = '0;

   ctdr_req_if req_ch ();
   ctdr_rsp_if rsp_ch ();

   color_to_depth_pixel_reprojection i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // bench copy of the camera setup, updated alongside each CSR write
   logic [63:0] cam_cf, cam_cc, cam_df, cam_dc;
   logic [62:0] cam_rot [3];
   logic [62:0] cam_tr;

   pixel_type pixel_q [$];      // words waiting for the driver
   proj_type  proj_q  [$];      // predicted results, oldest first
   int        errors = 0;
   int        gap_max = 12;     // sender idle draw range
   int        stall_max = 12;   // receiver stall draw range
   bit        long_hold = 1'b0; // request one long receiver hold-off
   longint    cycles = 0;

   function automatic longint f21(input logic [62:0] w, input int k);
      logic signed [20:0] x;
      x = w[21*k +: 21];
      return longint'(x);
   endfunction

   // trunc(a*b/c), magnitude clamped to the inner cap
   function automatic longint scale_div(input longint a, input logic [63:0] b,
                                        input logic [63:0] c, inout bit sat);
      logic [63:0]  m;
      logic [127:0] prod;
      logic [127:0] q;
      m    = (a < 0) ? 64'(-a) : 64'(a);
      prod = {64'b0, m} * {64'b0, b};
      if (prod == 0) return 0;
      if (c == 0) begin
         q   = 128'(PIX_CAP);
         sat = 1'b1;
      end else begin
         q = prod / {64'b0, c};
         if (q > 128'(PIX_CAP)) begin
            q   = 128'(PIX_CAP);
            sat = 1'b1;
         end
      end
      return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic [20:0] to_pixel(input longint q, input logic [31:0] c,
                                            inout bit sat);
      longint r;
      r = (q + longint'({32'b0, c})) / 4096;   // toward zero
      if (r > PIX_MAX) begin r = PIX_MAX; sat = 1'b1; end
      if (r < PIX_MIN) begin r = PIX_MIN; sat = 1'b1; end
      return r[20:0];
   endfunction

   function automatic proj_type reproject(input pixel_type px);
      proj_type res;
      bit       sat;
      longint   du, dv, p [3], pd [3];
      longint   qu, qv;
      sat = 1'b0;
      du = longint'({36'b0, px.u, 12'b0}) - longint'({32'b0, cam_cc[63:32]});
      dv = longint'({36'b0, px.v, 12'b0}) - longint'({32'b0, cam_cc[31:0]});
      p[0] = scale_div(du, {32'b0, px.z, 16'b0}, {32'b0, cam_cf[63:32]}, sat)
             - f21(cam_tr, 0) * 65536;
      p[1] = scale_div(dv, {32'b0, px.z, 16'b0}, {32'b0, cam_cf[31:0]}, sat)
             - f21(cam_tr, 1) * 65536;
      p[2] = longint'({32'b0, px.z, 16'b0}) - f21(cam_tr, 2) * 65536;
      for (int j = 0; j < 3; j++) begin
         pd[j] = 0;
         for (int i = 0; i < 3; i++) pd[j] += f21(cam_rot[i], j) * p[i];
      end
      if (pd[2] <= 0) begin
         // point behind the depth camera: pass the colour coordinate through
         res.du = {5'b0, px.u};
         res.dv = {5'b0, px.v};
         res.degen = 1'b1;
         res.sat = 1'b0;
         return res;
      end
      qu = scale_div(pd[0], {32'b0, cam_df[63:32]}, 64'(pd[2]), sat);
      qv = scale_div(pd[1], {32'b0, cam_df[31:0]}, 64'(pd[2]), sat);
      res.du = to_pixel(qu, cam_dc[63:32], sat);
      res.dv = to_pixel(qv, cam_dc[31:0], sat);
      res.degen = 1'b0;
      res.sat = sat;
      return res;
   endfunction

   task automatic report(input string what, input logic [20:0] got,
                         input logic [20:0] want);
      $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------- driver
   // A word stays on the bus until taken; the idle draw starts after that.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            proj_q.push_back(reproject({req_ch.color_u, req_ch.color_v, req_ch.depth_mm}));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               pixel_type px;
               px = pixel_q.pop_front();
               req_ch.color_u  <= px.u;
               req_ch.color_v  <= px.v;
               req_ch.depth_mm <= px.z;
               req_ch.valid    <= 1'b1;
               gap_left <= $urandom_range(0, gap_max);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.color_u = '0;
      req_ch.color_v = '0;
      req_ch.depth_mm = '0;
      rsp_ch.ready = 1'b0;
   end

   // --------------------------------------------------------------- monitor
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (proj_q.size() == 0) begin
               report("unexpected word", rsp_ch.depth_u, '0);
            end else begin
               proj_type want;
               want = proj_q.pop_front();
               if (rsp_ch.depth_u !== want.du) report("depth_u", rsp_ch.depth_u, want.du);
               if (rsp_ch.depth_v !== want.dv) report("depth_v", rsp_ch.depth_v, want.dv);
               if (rsp_ch.degenerate !== want.degen)
                  report("degenerate", 21'(rsp_ch.degenerate), 21'(want.degen));
               if (rsp_ch.saturated !== want.sat)
                  report("saturated", 21'(rsp_ch.saturated), 21'(want.sat));
            end
         end
         if (long_hold) begin
            long_hold <= 1'b0;
            hold_left <= 400;       // lets the pipeline fill and push back
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            int h;
            h = $urandom_range(0, stall_max);
            hold_left <= (h > 0) ? h - 1 : 0;
            rsp_ch.ready <= (h == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- sequencer
   task automatic write_reg(input ctdr_pkg::reg_index_type idx, input logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         ctdr_pkg::REG_COLOR_FOCAL:  cam_cf = data;
         ctdr_pkg::REG_COLOR_CENTER: cam_cc = data;
         ctdr_pkg::REG_DEPTH_FOCAL:  cam_df = data;
         ctdr_pkg::REG_DEPTH_CENTER: cam_dc = data;
         ctdr_pkg::REG_ROT_ROW0:     cam_rot[0] = data[62:0];
         ctdr_pkg::REG_ROT_ROW1:     cam_rot[1] = data[62:0];
         ctdr_pkg::REG_ROT_ROW2:     cam_rot[2] = data[62:0];
         default:                    cam_tr = data[62:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // waits until the pipeline has drained completely
   task automatic drain();
      while (pixel_q.size() > 0 || req_ch.valid || proj_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [62:0] pack3(input int a, input int b, input int c);
      return {21'(c), 21'(b), 21'(a)};
   endfunction

   // plausible RGB-D rig, with small random perturbations
   task automatic load_rig();
      int r;
      r = $urandom_range(0, 4000);
      write_reg(ctdr_pkg::REG_COLOR_FOCAL,
                {32'((600 << 16) + r * 97), 32'((600 << 16) - r * 61)});
      write_reg(ctdr_pkg::REG_COLOR_CENTER, {32'(320 << 16) + 32'(r), 32'(240 << 16)});
      write_reg(ctdr_pkg::REG_DEPTH_FOCAL,
                {32'(580 << 16) + 32'($urandom_range(0, 65535)), 32'(580 << 16)});
      write_reg(ctdr_pkg::REG_DEPTH_CENTER, {32'(319 << 16), 32'(239 << 16) + 32'(r)});
      write_reg(ctdr_pkg::REG_ROT_ROW0, pack3(262144 - r, r, -r));
      write_reg(ctdr_pkg::REG_ROT_ROW1, pack3(-r, 262144, r / 2));
      write_reg(ctdr_pkg::REG_ROT_ROW2, pack3(r, -r / 2, 262144 - r / 3));
      write_reg(ctdr_pkg::REG_TRANSLATION, pack3(-25 - r / 100, 3, $urandom_range(0, 40)));
   endtask

   task automatic load_random();
      for (int i = 0; i < 8; i++)
         write_reg(ctdr_pkg::reg_index_type'(i), {$urandom, $urandom});
   endtask

   function automatic pixel_type rand_pixel();
      pixel_type px;
      if ($urandom_range(0, 3) == 0) begin
         px = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else begin
         px.u = 16'($urandom_range(0, 640 * 16));
         px.v = 16'($urandom_range(0, 480 * 16));
         px.z = 16'($urandom_range(200, 8000));
      end
      return px;
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         pixel_q.push_back(rand_pixel());
         if (pixel_q.size() > 16) @(posedge clock);
      end
   endtask

   initial begin
      cam_cf = '0; cam_cc = '0; cam_df = '0; cam_dc = '0;
      cam_rot[0] = '0; cam_rot[1] = '0; cam_rot[2] = '0; cam_tr = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset setup: everything zero, so every pixel comes out degenerate
      pixel_q.push_back({16'h0000, 16'h0000, 16'h0000});
      pixel_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
      drain();

      // directed: field extremes on a normal rig, near and far depth
      load_rig();
      pixel_q.push_back({16'h0000, 16'h0000, 16'h0000});
      pixel_q.push_back({16'h0000, 16'h0000, 16'd1});
      pixel_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
      pixel_q.push_back({16'hFFFF, 16'h0000, 16'd1000});
      pixel_q.push_back({16'h0000, 16'hFFFF, 16'd1000});
      pixel_q.push_back({16'd5120, 16'd3840, 16'd1000});
      pixel_q.push_back({16'd5120, 16'd3840, 16'hFFFF});
      pixel_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
      pixel_q.push_back({16'h5555, 16'hAAAA, 16'h5555});
      pixel_q.push_back({16'd10, 16'd7000, 16'd30});     // behind the camera
      drain();

      // zero colour focal length: zero numerator versus clamp
      write_reg(ctdr_pkg::REG_COLOR_FOCAL, 64'd0);
      pixel_q.push_back({16'd5120, 16'd3840, 16'd1000});
      pixel_q.push_back({16'd20, 16'd7000, 16'd1000});
      pixel_q.push_back({16'd5120, 16'd3840, 16'd0});
      drain();

      // register extremes: all ones
      for (int i = 0; i < 8; i++) write_reg(ctdr_pkg::reg_index_type'(i), '1);
      pixel_q.push_back({16'd0, 16'd0, 16'hFFFF});
      pixel_q.push_back({16'hFFFF, 16'hFFFF, 16'd1});
      pixel_q.push_back({16'h1234, 16'h4321, 16'd500});
      drain();

      // random rig with no idling, then the long receiver hold-off
      load_rig();
      gap_max = 0;
      stall_max = 0;
      run_random(200);
      long_hold = 1'b1;
      run_random(200);
      drain();

      // random idling on both sides
      gap_max = 12;
      stall_max = 12;
      load_rig();
      run_random(300);
      drain();

      load_random();
      run_random(100);
      drain();

      load_rig();
      stall_max = 0;
      run_random(200);
      drain();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/ctdr_pkg.sv
design/ctdr_req_if.sv
design/ctdr_rsp_if.sv
design/ctdr_div.sv
design/ctdr_rot.sv
design/color_to_depth_pixel_reprojection.sv
dv/color_to_depth_pixel_reprojection_tb.sv
